>>> hw/rtl/lpfe_pkg.sv
// Package: shared types, codes and reset values of the length-prefixed frame extractor.
package lpfe_pkg;

	localparam logic [7:0]  START_MARKER_RST = 8'h7E;
	localparam logic [31:0] MAX_LEN_RST      = 32'd1048576;
	localparam logic        BIG_ENDIAN_RST   = 1'b0;

	localparam int unsigned ADDR_W = 4;

	typedef enum logic [1:0] {
		REG_START_MARKER = 2'd0,
		REG_MAX_LEN      = 2'd1,
		REG_BIG_ENDIAN   = 2'd2,
		REG_NONE         = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		EV_PAYLOAD  = 2'd0,
		EV_EMPTY    = 2'd1,
		EV_BADSTART = 2'd2,
		EV_REFUSED  = 2'd3
	} ev_kind_t;

	typedef enum logic [1:0] {
		PH_START   = 2'd0,
		PH_LENGTH  = 2'd1,
		PH_COUNT   = 2'd2,
		PH_PAYLOAD = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0]  start_marker;
		logic [31:0] max_payload_length;
		logic        length_big_endian;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		ev_kind_t    event_kind;
		logic [7:0]  payload_byte;
		logic        frame_last;
	} res_t;

endpackage

>>> hw/rtl/lpfe_rx_if.sv
// Interface: received byte channel.
interface lpfe_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

>>> hw/rtl/lpfe_evt_if.sv
// Interface: frame event channel.
interface lpfe_evt_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_kind;
	logic [7:0] payload_byte;
	logic       frame_last;

	modport source (output valid, output event_kind, output payload_byte, output frame_last,
		input ready);
	modport sink (input valid, input event_kind, input payload_byte, input frame_last,
		output ready);
endinterface

>>> hw/rtl/length_prefixed_frame_extractor.sv
// Top level: length-prefixed frame extractor with input and result stages.
// A transferred byte is registered in the input stage, and its event, if any, in the result stage.
// Throughput: one byte per cycle; the input stage loads whenever it is empty, and both
// stages advance when the result register is empty or its event is being transferred.
// Header bytes and the payload counter are handled by the parser between the two stages.
// Reset (arst_n low, asynchronous): both stages empty, parser waiting for a start marker,
// halt cleared, registers back to marker 0x7E, limit 1048576, little-endian length.
module length_prefixed_frame_extractor (
	input  logic                        clk,
	input  logic                        arst_n,
	lpfe_rx_if.sink                     rx,
	lpfe_evt_if.source                  evt,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lpfe_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import lpfe_pkg::*;

	cfg_t       cfg;
	res_t       res;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// result stage
	logic       valid_s2;
	ev_kind_t   kind_s2;
	logic [7:0] data_s2;
	logic       last_s2;

	logic       advance;
	logic       step;

	// Advance both stages whenever the result slot is free or being emptied.
	assign advance  = !valid_s2 || evt.ready;
	assign rx.ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	lpfe_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lpfe_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// Capture each transferred byte; hold it while the result stage is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready)
			byte_s1 <= rx.rx_byte;
	end

	// Load the parser's event, or drop to empty when the byte gave none.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_s2 <= res.event_kind;
			data_s2 <= res.payload_byte;
			last_s2 <= res.frame_last;
		end
	end

	assign evt.valid        = valid_s2;
	assign evt.event_kind   = kind_s2;
	assign evt.payload_byte = data_s2;
	assign evt.frame_last   = last_s2;

	a_err_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (kind_s2 == EV_BADSTART || kind_s2 == EV_REFUSED) |-> !last_s2)
		else $error("error event flagged as frame end");
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && kind_s2 == EV_EMPTY |-> last_s2 && data_s2 == 8'd0)
		else $error("empty-frame marker malformed");
	a_step_only_stage: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> !valid_s1 || $past(rx.valid))
		else $error("input stage filled without a transfer");

endmodule

>>> hw/rtl/lpfe_cfg_regs.sv
// Configuration registers behind the APB-style port.
module lpfe_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lpfe_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output lpfe_pkg::cfg_t               cfg
);
	import lpfe_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_marker       <= START_MARKER_RST;
			cfg_q.max_payload_length <= MAX_LEN_RST;
			cfg_q.length_big_endian  <= BIG_ENDIAN_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_START_MARKER: cfg_q.start_marker       <= pwdata[7:0];
				REG_MAX_LEN:      cfg_q.max_payload_length <= pwdata;
				REG_BIG_ENDIAN:   cfg_q.length_big_endian  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_START_MARKER: prdata = {24'd0, cfg_q.start_marker};
			REG_MAX_LEN:      prdata = cfg_q.max_payload_length;
			REG_BIG_ENDIAN:   prdata = {31'd0, cfg_q.length_big_endian};
			default:          prdata = 32'd0;
		endcase
	end

endmodule

>>> hw/rtl/lpfe_parser.sv
// Frame parser: header state machine, payload counter and event decode.
module lpfe_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       rx_byte,
	input  lpfe_pkg::cfg_t   cfg,
	output lpfe_pkg::res_t   res
);
	import lpfe_pkg::*;

	phase_t      phase_q, phase_d;
	logic [31:0] gather_q, gather_d;
	logic [1:0]  idx_q, idx_d;
	logic [31:0] remain_q, remain_d;
	logic        halted_q, halted_d;
	logic        refuse;
	logic        last_byte;

	assign refuse    = gather_q > cfg.max_payload_length;
	assign last_byte = remain_q == 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			gather_q <= 32'd0;
			idx_q    <= 2'd0;
			remain_q <= 32'd0;
			halted_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			gather_q <= gather_d;
			idx_q    <= idx_d;
			remain_q <= remain_d;
			halted_q <= halted_d;
		end
	end

	// next state
	always_comb begin
		phase_d  = phase_q;
		gather_d = gather_q;
		idx_d    = idx_q;
		remain_d = remain_q;
		halted_d = halted_q;
		if (step && !halted_q) begin
			unique case (phase_q)
				PH_LENGTH: begin
					if (cfg.length_big_endian)
						gather_d = {gather_q[23:0], rx_byte};
					else
						gather_d = gather_q | (32'(rx_byte) << {idx_q, 3'b000});
					if (idx_q == 2'd3) begin
						idx_d   = 2'd0;
						phase_d = PH_COUNT;
					end else begin
						idx_d = idx_q + 2'd1;
					end
				end
				PH_COUNT: begin
					if (refuse) begin
						halted_d = 1'b1;
						phase_d  = PH_START;
					end else if (gather_q == 32'd0) begin
						phase_d = PH_START;
					end else begin
						remain_d = gather_q;
						phase_d  = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					remain_d = remain_q - 32'd1;
					if (last_byte)
						phase_d = PH_START;
				end
				default: begin
					if (rx_byte != cfg.start_marker) begin
						halted_d = 1'b1;
					end else begin
						gather_d = 32'd0;
						idx_d    = 2'd0;
						remain_d = 32'd0;
						phase_d  = PH_LENGTH;
					end
				end
			endcase
		end
	end

	// event decode
	always_comb begin
		res = '{valid: 1'b0, event_kind: EV_PAYLOAD, payload_byte: 8'd0, frame_last: 1'b0};
		if (step && !halted_q) begin
			unique case (phase_q)
				PH_LENGTH: ;
				PH_COUNT: begin
					if (refuse) begin
						res.valid      = 1'b1;
						res.event_kind = EV_REFUSED;
					end else if (gather_q == 32'd0) begin
						res.valid      = 1'b1;
						res.event_kind = EV_EMPTY;
						res.frame_last = 1'b1;
					end
				end
				PH_PAYLOAD: begin
					res.valid        = 1'b1;
					res.payload_byte = rx_byte;
					res.frame_last   = last_byte;
				end
				default: begin
					if (rx_byte != cfg.start_marker) begin
						res.valid      = 1'b1;
						res.event_kind = EV_BADSTART;
					end
				end
			endcase
		end
	end

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q) else $error("halt released without reset");
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !res.valid) else $error("event produced while halted");
	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> remain_q != 32'd0) else $error("payload phase with no bytes left");

endmodule

>>> test/tb_top.sv
// Testbench for the length-prefixed frame extractor: directed frames, random frames, checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lpfe_pkg::*;

	localparam int unsigned LATENCY     = 4;       // settling edges after the drain
	localparam int unsigned CYCLE_LIMIT = 400000;  // slowest correct run is well under this
	localparam int unsigned DRAIN_LIMIT = 5000;
	localparam int unsigned HOLD_CYCLES = 150;     // long receiver hold-off
	localparam int unsigned PHASE_BYTES = 95;      // minimum bytes per random register setting
	localparam int unsigned NUM_SETTINGS = 8;

	// Frame event predictor and store of events still to arrive.
	class frame_event_tracker;
		typedef struct {
			ev_kind_t   kind;
			logic [7:0] data;
			logic       last;
		} frame_event_t;

		frame_event_t expected_events[$];

		// register copies
		logic [7:0]  marker;
		logic [31:0] max_len;
		logic        big_endian;

		// parser state
		phase_t      phase;
		logic [31:0] gather;
		logic [1:0]  hdr_idx;
		logic [31:0] remaining;
		bit          halted;

		int unsigned fail_count;
		int unsigned events_seen;

		function new();
			marker      = START_MARKER_RST;
			max_len     = MAX_LEN_RST;
			big_endian  = BIG_ENDIAN_RST;
			phase       = PH_START;
			gather      = '0;
			hdr_idx     = '0;
			remaining   = '0;
			halted      = 1'b0;
			fail_count  = 0;
			events_seen = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] val);
			case (idx)
				REG_START_MARKER: marker = val[7:0];
				REG_MAX_LEN:      max_len = val;
				REG_BIG_ENDIAN:   big_endian = val[0];
				default: ;
			endcase
		endfunction

		function logic [31:0] reg_value(reg_idx_t idx);
			case (idx)
				REG_START_MARKER: return {24'd0, marker};
				REG_MAX_LEN:      return max_len;
				REG_BIG_ENDIAN:   return {31'd0, big_endian};
				default:          return '0;
			endcase
		endfunction

		function void note_failure(string what);
			fail_count++;
			if (fail_count <= 10) begin
				$display("tb_top: mismatch: %s", what);
			end
		endfunction

		function void push_event(ev_kind_t kind, logic [7:0] data, logic last);
			frame_event_t e;
			e.kind = kind;
			e.data = data;
			e.last = last;
			expected_events.push_back(e);
		endfunction

		function int unsigned pending();
			return expected_events.size();
		endfunction

		// Advance the parser by one transferred byte.
		function void take_byte(logic [7:0] b);
			if (halted) begin
				return;
			end
			case (phase)
				PH_LENGTH: begin
					if (big_endian) begin
						gather = {gather[23:0], b};
					end else begin
						gather = gather | (32'(b) << (8 * hdr_idx));
					end
					if (hdr_idx == 2'd3) begin
						hdr_idx = '0;
						phase = PH_COUNT;
					end else begin
						hdr_idx = hdr_idx + 2'd1;
					end
				end
				PH_COUNT: begin
					if (gather > max_len) begin
						halted = 1'b1;
						phase = PH_START;
						push_event(EV_REFUSED, 8'd0, 1'b0);
					end else if (gather == 32'd0) begin
						phase = PH_START;
						push_event(EV_EMPTY, 8'd0, 1'b1);
					end else begin
						remaining = gather;
						phase = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					remaining = remaining - 32'd1;
					if (remaining == 32'd0) begin
						phase = PH_START;
						push_event(EV_PAYLOAD, b, 1'b1);
					end else begin
						push_event(EV_PAYLOAD, b, 1'b0);
					end
				end
				default: begin
					if (b != marker) begin
						halted = 1'b1;
						phase = PH_START;
						push_event(EV_BADSTART, 8'd0, 1'b0);
					end else begin
						gather = '0;
						hdr_idx = '0;
						remaining = '0;
						phase = PH_LENGTH;
					end
				end
			endcase
		endfunction

		function void match_event(ev_kind_t kind, logic [7:0] data, logic last);
			frame_event_t e;
			events_seen++;
			if (expected_events.size() == 0) begin
				note_failure($sformatf("event kind %0d byte %02h last %0b with nothing expected",
					kind, data, last));
				return;
			end
			e = expected_events.pop_front();
			if (e.kind !== kind || e.data !== data || e.last !== last) begin
				note_failure($sformatf("expected kind %0d byte %02h last %0b, got kind %0d byte %02h last %0b",
					e.kind, e.data, e.last, kind, data, last));
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	lpfe_rx_if  rx_ch();
	lpfe_evt_if evt_ch();

	frame_event_tracker frame_events = new();

	bit          burst;      // no random gaps on either side while set
	bit          hold_req;   // ask the receiver for one long hold-off
	int unsigned cycle_count;
	int unsigned bytes_sent;
	int unsigned frames_sent;
	int unsigned settings_used;

	length_prefixed_frame_extractor u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_ch),
		.evt     (evt_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: cycle limit reached with %0d events outstanding",
				frame_events.pending());
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// Idle length: mostly none or short, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (burst) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Payload length, kept small so frames stay short; never above the limit.
	function automatic int unsigned pick_len(logic [31:0] limit);
		int unsigned r;
		int unsigned n;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			n = 0;
		end else if (r < 75) begin
			n = $urandom_range(1, 8);
		end else if (r < 95) begin
			n = $urandom_range(9, 32);
		end else begin
			n = $urandom_range(33, 64);
		end
		if (n > limit) begin
			n = limit;
		end
		return n;
	endfunction

	// Receiver: random stalls, plus one long hold-off on request so that both
	// stages fill and the input is stalled while the sender keeps offering.
	initial begin
		int unsigned n;
		evt_ch.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				evt_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				n = pick_gap();
				if (n > 0) begin
					evt_ch.ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
				evt_ch.ready <= 1'b1;
				n = $urandom_range(1, 8);
				repeat (n) @(posedge clk);
			end
		end
	end

	// Check every event transfer against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && evt_ch.valid && evt_ch.ready) begin
			frame_events.match_event(ev_kind_t'(evt_ch.event_kind), evt_ch.payload_byte,
				evt_ch.frame_last);
		end
	end

	// One APB transfer: setup cycle, then access until pready.
	task automatic apb_access(input logic wr, input reg_idx_t idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Write a register, then, unless it is the unused address, read it back against the predictor's copy.
	task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
		logic [31:0] rd;
		apb_access(1'b1, idx, val, rd);
		frame_events.set_reg(idx, val);
		if (idx != REG_NONE) begin
			apb_access(1'b0, idx, 32'd0, rd);
			if (rd !== frame_events.reg_value(idx)) begin
				frame_events.note_failure($sformatf("register %0d read %08h, expected %08h",
					idx, rd, frame_events.reg_value(idx)));
			end
		end
	endtask

	// Offer one byte and hold it until the transfer; valid is left high so
	// back-to-back bytes follow without an idle gap.
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		frame_events.take_byte(b);
		bytes_sent++;
	endtask

	// Drop valid and wait until every predicted event has arrived and the
	// stages have had time to empty.
	task automatic drain_pipeline();
		int unsigned guard;
		guard = 0;
		rx_ch.valid <= 1'b0;
		while (frame_events.pending() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (LATENCY) @(posedge clk);
	endtask

	// Marker, length in the configured byte order, random count byte.
	task automatic send_header(input logic [31:0] len);
		int unsigned i;
		send_byte(frame_events.marker);
		for (i = 0; i < 4; i++) begin
			if (frame_events.big_endian) begin
				send_byte(8'(len >> (8 * (3 - i))));
			end else begin
				send_byte(8'(len >> (8 * i)));
			end
		end
		send_byte(8'($urandom_range(0, 255)));
	endtask

	// Whole frame; with extremes set the payload alternates FF and 00.
	task automatic send_frame(input int unsigned len, input bit extremes);
		int unsigned i;
		send_header(len);
		for (i = 0; i < len; i++) begin
			if (extremes) begin
				send_byte(i[0] ? 8'h00 : 8'hFF);
			end else begin
				send_byte(8'($urandom_range(0, 255)));
			end
		end
		frames_sent++;
	endtask

	initial begin
		int unsigned p;
		int unsigned i;
		int unsigned phase_start;
		bit          refuse_path;

		arst_n        = 1'b0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = 8'd0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = 32'd0;
		burst         = 1'b0;
		hold_req      = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty frame under reset settings.
		send_frame(0, 1'b0);
		drain_pipeline();

		// Length equal to the limit, big-endian, zero marker; the write to the
		// unused address must leave everything as it was.
		cfg_write(REG_START_MARKER, 32'd0);
		cfg_write(REG_MAX_LEN, 32'd3);
		cfg_write(REG_BIG_ENDIAN, 32'd1);
		cfg_write(REG_NONE, 32'hFFFF_FFFF);
		send_frame(3, 1'b1);
		drain_pipeline();

		// Byte order flipped halfway through the length, and the limit lowered
		// to exactly the length just before the count byte.
		send_byte(frame_events.marker);
		send_byte(8'h00);
		send_byte(8'h02);
		drain_pipeline();
		cfg_write(REG_BIG_ENDIAN, 32'd0);
		send_byte(8'h00);
		send_byte(8'h00);
		drain_pipeline();
		cfg_write(REG_MAX_LEN, 32'd2);
		send_byte(8'hFF);
		send_byte(8'h81);
		send_byte(8'h7E);
		frames_sent++;
		drain_pipeline();

		// Random frames under a series of register settings.
		for (p = 0; p < NUM_SETTINGS; p++) begin
			case (p)
				0: begin
					cfg_write(REG_START_MARKER, 32'hFF);
					cfg_write(REG_MAX_LEN, 32'hFFFF_FFFF);
					cfg_write(REG_BIG_ENDIAN, 32'd0);
				end
				1: begin
					// only empty frames pass a zero limit
					cfg_write(REG_START_MARKER, 32'h00);
					cfg_write(REG_MAX_LEN, 32'd0);
					cfg_write(REG_BIG_ENDIAN, 32'd1);
				end
				2: begin
					cfg_write(REG_START_MARKER, $urandom_range(0, 255));
					cfg_write(REG_MAX_LEN, $urandom_range(1, 20));
					cfg_write(REG_BIG_ENDIAN, $urandom_range(0, 1));
				end
				3: begin
					cfg_write(REG_START_MARKER, $urandom_range(0, 255));
					cfg_write(REG_MAX_LEN, 32'd64);
					cfg_write(REG_BIG_ENDIAN, 32'd1);
					burst = 1'b1;
					hold_req = 1'b1;
				end
				4: begin
					cfg_write(REG_START_MARKER, $urandom_range(0, 255));
					cfg_write(REG_MAX_LEN, $urandom());
					cfg_write(REG_BIG_ENDIAN, 32'd0);
				end
				default: begin
					cfg_write(REG_START_MARKER, $urandom_range(0, 255));
					cfg_write(REG_MAX_LEN, $urandom_range(0, 48));
					cfg_write(REG_BIG_ENDIAN, $urandom_range(0, 1));
				end
			endcase
			settings_used++;
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES) begin
				send_frame(pick_len(frame_events.max_len), 1'b0);
			end
			drain_pipeline();
			burst = 1'b0;
		end

		// Close with one error; the block then stays halted until reset, so the
		// trailing bytes, a valid frame among them, must produce nothing.
		refuse_path = 1'($urandom_range(0, 1));
		if (refuse_path) begin
			cfg_write(REG_MAX_LEN, $urandom() & 32'hFFFF_FFFE);
			send_header(frame_events.max_len + 32'd1);
		end else begin
			send_byte(frame_events.marker ^ 8'($urandom_range(1, 255)));
		end
		send_header(32'd0);
		for (i = 0; i < 8; i++) begin
			send_byte(8'($urandom_range(0, 255)));
		end
		drain_pipeline();
		repeat (4 * LATENCY) @(posedge clk);

		if (frame_events.pending() != 0) begin
			frame_events.note_failure($sformatf("%0d events never arrived",
				frame_events.pending()));
		end

		$display("tb_top: %0d bytes in %0d frames over %0d register settings, %0d events checked",
			bytes_sent, frames_sent, settings_used, frame_events.events_seen);
		$display("tb_top: halted by a %s, %0d failures",
			refuse_path ? "refused length" : "bad start byte", frame_events.fail_count);
		if (frame_events.fail_count == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
